FILE: rtl/tpf_pkg.sv
package tpf_pkg;

  localparam int XW    = 16;               // abscissa width
  localparam int YW    = 24;               // ordinate width
  localparam int FB    = 16;               // fraction bits of the coefficients
  localparam int OW    = 48;               // coefficient width
  localparam int DW    = XW + 1;           // difference / sum of two abscissas
  localparam int PW    = 2 * DW;           // product of two differences
  localparam int XXW   = 2 * XW;           // product of two abscissas
  localparam int WW    = XXW + DW;         // x*x*d
  localparam int WL    = 25;               // low split of WW for the y*x*x*d product
  localparam int DENW  = 3 * DW;           // denominator
  localparam int Q2W   = YW + DW;          // y*d
  localparam int UW    = YW + PW;          // y*d*s
  localparam int N2W   = Q2W + 3;
  localparam int N1W   = UW + 2;
  localparam int N0W   = YW + WW + 3;
  localparam int NMW   = N0W + FB;         // scaled numerator magnitude
  localparam int DIVL  = OW + 1;           // divider latency
  localparam int FRONTL = 6;               // front end latency
  localparam int VL    = FRONTL + 1 + DIVL + 1;

  localparam logic [OW-1:0] SAT_POS = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] SAT_NEG = {1'b1, {(OW-1){1'b0}}};

  localparam logic FIT_OK      = 1'b0;
  localparam logic FIT_INVALID = 1'b1;

  typedef struct packed {
    logic signed [N0W-1:0]  n0;
    logic signed [N1W-1:0]  n1;
    logic signed [N2W-1:0]  n2;
    logic signed [DENW-1:0] den;
    logic                   bad;
  } front_out_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       bad;
  } side_t;

  function automatic logic [N0W-1:0] mag_num(input logic signed [N0W-1:0] v);
    return v[N0W-1] ? N0W'(-v) : N0W'(v);
  endfunction

endpackage

FILE: rtl/three_point_parabola_fit.sv
// Three-point parabola fit, fully pipelined.
// Stages from an accepted input transaction to out_valid
// (6 multiply/add stages, 1 magnitude stage, 49 divider stages, 1 output stage).
// Throughput: one transaction per unstalled cycle; one quotient bit per divider stage.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, rst_n low) clears all valid bits; data registers are not reset.
module three_point_parabola_fit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [tpf_pkg::XW-1:0] in_x_first,
  input  logic signed [tpf_pkg::YW-1:0] in_y_first,
  input  logic signed [tpf_pkg::XW-1:0] in_x_second,
  input  logic signed [tpf_pkg::YW-1:0] in_y_second,
  input  logic signed [tpf_pkg::XW-1:0] in_x_third,
  input  logic signed [tpf_pkg::YW-1:0] in_y_third,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [tpf_pkg::OW-1:0] out_coef_const,
  output logic signed [tpf_pkg::OW-1:0] out_coef_linear,
  output logic signed [tpf_pkg::OW-1:0] out_coef_square,
  output logic                          out_fit_status,
  output logic                          out_clipped
);
  import tpf_pkg::*;

  logic            en;
  logic [VL-1:0]   vld_r;
  front_out_t      fo;

  logic [NMW-1:0]  nmag_r [0:2];
  logic [DENW-1:0] dmag_r;
  side_t           side_g_r;
  side_t           side_r [0:DIVL-1];

  logic [OW-1:0]   quo [0:2];
  logic [2:0]      big;

  logic [OW-1:0]   coef_nxt [0:2];
  logic [2:0]      clip_nxt;
  logic [OW-1:0]   coef_r   [0:2];
  logic            status_r, clip_r;

  assign en       = !vld_r[VL-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VL-2:0], in_valid};
    end
  end

  tpf_front u_front (
    .clk (clk),
    .en  (en),
    .x1  (in_x_first),
    .y1  (in_y_first),
    .x2  (in_x_second),
    .y2  (in_y_second),
    .x3  (in_x_third),
    .y3  (in_y_third),
    .fo  (fo)
  );

  // magnitudes and quotient signs
  always_ff @(posedge clk) begin
    if (en) begin
      nmag_r[0]   <= NMW'(mag_num(fo.n0)) << FB;
      nmag_r[1]   <= NMW'(mag_num(N0W'(fo.n1))) << FB;
      nmag_r[2]   <= NMW'(mag_num(N0W'(fo.n2))) << FB;
      dmag_r      <= fo.den[DENW-1] ? DENW'(-fo.den) : DENW'(fo.den);
      side_g_r.neg <= {fo.n2[N2W-1] ^ fo.den[DENW-1],
                       fo.n1[N1W-1] ^ fo.den[DENW-1],
                       fo.n0[N0W-1] ^ fo.den[DENW-1]};
      side_g_r.bad <= fo.bad;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tpf_divider u_div (
      .clk (clk),
      .en  (en),
      .num (nmag_r[i]),
      .den (dmag_r),
      .quo (quo[i]),
      .big (big[i])
    );

    always_comb begin
      if (side_r[DIVL-1].neg[i]) begin
        clip_nxt[i] = big[i] || (quo[i][OW-1] && (|quo[i][OW-2:0]));
        coef_nxt[i] = clip_nxt[i] ? SAT_NEG : OW'(-quo[i]);
      end else begin
        clip_nxt[i] = big[i] || quo[i][OW-1];
        coef_nxt[i] = clip_nxt[i] ? SAT_POS : quo[i];
      end
    end
  end

  // carry signs and the invalid flag alongside the divider
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_g_r;
      for (int k = 1; k < DIVL; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (side_r[DIVL-1].bad) begin
        coef_r[0] <= '0;
        coef_r[1] <= '0;
        coef_r[2] <= '0;
        status_r  <= FIT_INVALID;
        clip_r    <= 1'b0;
      end else begin
        coef_r[0] <= coef_nxt[0];
        coef_r[1] <= coef_nxt[1];
        coef_r[2] <= coef_nxt[2];
        status_r  <= FIT_OK;
        clip_r    <= |clip_nxt;
      end
    end
  end

  assign out_valid       = vld_r[VL-1];
  assign out_coef_const  = $signed(coef_r[0]);
  assign out_coef_linear = $signed(coef_r[1]);
  assign out_coef_square = $signed(coef_r[2]);
  assign out_fit_status  = status_r;
  assign out_clipped     = clip_r;

endmodule

FILE: rtl/tpf_front.sv
module tpf_front (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [tpf_pkg::XW-1:0]  x1,
  input  logic signed [tpf_pkg::YW-1:0]  y1,
  input  logic signed [tpf_pkg::XW-1:0]  x2,
  input  logic signed [tpf_pkg::YW-1:0]  y2,
  input  logic signed [tpf_pkg::XW-1:0]  x3,
  input  logic signed [tpf_pkg::YW-1:0]  y3,
  output tpf_pkg::front_out_t            fo
);
  import tpf_pkg::*;

  // stage A
  logic signed [DW-1:0]  d12_r, d13_r, d23_r, d31_r, s23_r, s31_r, s12_r;
  logic signed [XW-1:0]  xa1_r, xa2_r, xa3_r;
  logic signed [YW-1:0]  ya1_r, ya2_r, ya3_r;
  logic                  bad_a_r;
  // stage B
  logic signed [PW-1:0]  pden_r, t1_r, t2_r, t3_r;
  logic signed [Q2W-1:0] q1_r, q2_r, q3_r;
  logic signed [XXW-1:0] xx1_r, xx2_r, xx3_r;
  logic signed [DW-1:0]  db12_r, db23_r, db31_r;
  logic signed [YW-1:0]  yb1_r, yb2_r, yb3_r;
  logic                  bad_b_r;
  // stage C
  logic signed [DENW-1:0] den_c_r;
  logic signed [N2W-1:0]  n2_c_r;
  logic signed [UW-1:0]   u1_r, u2_r, u3_r;
  logic signed [WW-1:0]   w1_r, w2_r, w3_r;
  logic signed [YW-1:0]   yc1_r, yc2_r, yc3_r;
  logic                   bad_c_r;
  // stage D
  logic signed [DENW-1:0]    den_d_r;
  logic signed [N2W-1:0]     n2_d_r;
  logic signed [N1W-1:0]     n1_d_r;
  logic signed [YW+WL:0]     pl1_r, pl2_r, pl3_r;
  logic signed [YW+WW-WL-1:0] ph1_r, ph2_r, ph3_r;
  logic                      bad_d_r;
  // stage E
  logic signed [DENW-1:0] den_e_r;
  logic signed [N2W-1:0]  n2_e_r;
  logic signed [N1W-1:0]  n1_e_r;
  logic signed [N0W-1:0]  v1_r, v2_r, v3_r;
  logic                   bad_e_r;
  // stage F
  front_out_t fo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d12_r   <= DW'(x1) - DW'(x2);
      d13_r   <= DW'(x1) - DW'(x3);
      d23_r   <= DW'(x2) - DW'(x3);
      d31_r   <= DW'(x3) - DW'(x1);
      s23_r   <= DW'(x2) + DW'(x3);
      s31_r   <= DW'(x3) + DW'(x1);
      s12_r   <= DW'(x1) + DW'(x2);
      xa1_r   <= x1;
      xa2_r   <= x2;
      xa3_r   <= x3;
      ya1_r   <= y1;
      ya2_r   <= y2;
      ya3_r   <= y3;
      bad_a_r <= (x1 == x2) || (x1 == x3) || (x2 == x3);

      pden_r  <= d12_r * d13_r;
      t1_r    <= d23_r * s23_r;
      t2_r    <= d31_r * s31_r;
      t3_r    <= d12_r * s12_r;
      q1_r    <= ya1_r * d23_r;
      q2_r    <= ya2_r * d31_r;
      q3_r    <= ya3_r * d12_r;
      xx1_r   <= xa2_r * xa3_r;
      xx2_r   <= xa3_r * xa1_r;
      xx3_r   <= xa1_r * xa2_r;
      db12_r  <= d12_r;
      db23_r  <= d23_r;
      db31_r  <= d31_r;
      yb1_r   <= ya1_r;
      yb2_r   <= ya2_r;
      yb3_r   <= ya3_r;
      bad_b_r <= bad_a_r;

      den_c_r <= pden_r * db23_r;
      n2_c_r  <= N2W'(q1_r) + N2W'(q2_r) + N2W'(q3_r);
      u1_r    <= yb1_r * t1_r;
      u2_r    <= yb2_r * t2_r;
      u3_r    <= yb3_r * t3_r;
      w1_r    <= xx1_r * db23_r;
      w2_r    <= xx2_r * db31_r;
      w3_r    <= xx3_r * db12_r;
      yc1_r   <= yb1_r;
      yc2_r   <= yb2_r;
      yc3_r   <= yb3_r;
      bad_c_r <= bad_b_r;

      // split y*x*x*d into two narrower partial products
      den_d_r <= den_c_r;
      n2_d_r  <= n2_c_r;
      n1_d_r  <= -(N1W'(u1_r) + N1W'(u2_r) + N1W'(u3_r));
      pl1_r   <= yc1_r * $signed({1'b0, w1_r[WL-1:0]});
      pl2_r   <= yc2_r * $signed({1'b0, w2_r[WL-1:0]});
      pl3_r   <= yc3_r * $signed({1'b0, w3_r[WL-1:0]});
      ph1_r   <= yc1_r * $signed(w1_r[WW-1:WL]);
      ph2_r   <= yc2_r * $signed(w2_r[WW-1:WL]);
      ph3_r   <= yc3_r * $signed(w3_r[WW-1:WL]);
      bad_d_r <= bad_c_r;

      den_e_r <= den_d_r;
      n2_e_r  <= n2_d_r;
      n1_e_r  <= n1_d_r;
      v1_r    <= (N0W'(ph1_r) <<< WL) + N0W'(pl1_r);
      v2_r    <= (N0W'(ph2_r) <<< WL) + N0W'(pl2_r);
      v3_r    <= (N0W'(ph3_r) <<< WL) + N0W'(pl3_r);
      bad_e_r <= bad_d_r;

      fo_r.n0  <= v1_r + v2_r + v3_r;
      fo_r.n1  <= n1_e_r;
      fo_r.n2  <= n2_e_r;
      fo_r.den <= den_e_r;
      fo_r.bad <= bad_e_r;
    end
  end

  assign fo = fo_r;

endmodule

FILE: rtl/tpf_divider.sv
module tpf_divider (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tpf_pkg::NMW-1:0]       num,
  input  logic [tpf_pkg::DENW-1:0]      den,
  output logic [tpf_pkg::OW-1:0]        quo,
  output logic                          big
);
  import tpf_pkg::*;

  logic [DENW-1:0] rem_r [0:OW];
  logic [OW-1:0]   lo_r  [0:OW];
  logic [DENW-1:0] d_r   [0:OW];
  logic            big_r [0:OW];

  // entry stage: quotient needs more than OW bits when the high part reaches den
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DENW'(num[NMW-1:OW]);
      lo_r[0]  <= num[OW-1:0];
      d_r[0]   <= den;
      big_r[0] <= (den <= DENW'(num[NMW-1:OW]));
    end
  end

  // one quotient bit per stage, shifted into the low word
  for (genvar k = 0; k < OW; k++) begin : g_step
    logic [DENW:0]   r2;
    logic            ge;
    logic [DENW-1:0] rem_nxt;

    always_comb begin
      r2      = {rem_r[k], lo_r[k][OW-1]};
      ge      = (r2 >= {1'b0, d_r[k]});
      rem_nxt = ge ? DENW'(r2 - {1'b0, d_r[k]}) : r2[DENW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= rem_nxt;
        lo_r[k+1]  <= {lo_r[k][OW-2:0], ge};
        d_r[k+1]   <= d_r[k];
        big_r[k+1] <= big_r[k];
      end
    end
  end

  assign quo = lo_r[OW];
  assign big = big_r[OW];

endmodule

FILE: tb/sv/three_point_parabola_fit_test.sv
`timescale 1ns / 1ps

module three_point_parabola_fit_test;
  import tpf_pkg::*;

  typedef struct {
    logic signed [OW-1:0] c0, c1, c2;
    logic status, clip;
  } fit_t;

  class fit_board;
    fit_t pending[$];
    int errors;

    // trunc(num * 2^FB / den), saturated to OW bits
    function logic signed [OW-1:0] scaled_quot(logic signed [255:0] num,
                                               logic signed [255:0] den,
                                               ref logic clip);
      logic signed [255:0] q;
      q = (num <<< FB) / den;
      if (q > 256'sd140737488355327) begin
        clip = 1'b1;
        return SAT_POS;
      end
      if (q < -256'sd140737488355328) begin
        clip = 1'b1;
        return SAT_NEG;
      end
      return q[OW-1:0];
    endfunction

    function void note_points(logic signed [XW-1:0] xa, logic signed [YW-1:0] ya,
                              logic signed [XW-1:0] xb, logic signed [YW-1:0] yb,
                              logic signed [XW-1:0] xc, logic signed [YW-1:0] yc);
      logic signed [255:0] x1, x2, x3, y1, y2, y3, d12, d23, d31, den, n0, n1, n2;
      fit_t f;
      f.c0 = '0; f.c1 = '0; f.c2 = '0; f.clip = 1'b0; f.status = FIT_OK;
      if (xa == xb || xa == xc || xb == xc) begin
        f.status = FIT_INVALID;
      end else begin
        x1 = xa; x2 = xb; x3 = xc; y1 = ya; y2 = yb; y3 = yc;
        d12 = x1 - x2; d23 = x2 - x3; d31 = x3 - x1;
        den = -(d12 * d31 * d23);
        n2 = y1 * d23 + y2 * d31 + y3 * d12;
        n1 = -(y1 * d23 * (x2 + x3) + y2 * d31 * (x3 + x1) + y3 * d12 * (x1 + x2));
        n0 = y1 * x2 * x3 * d23 + y2 * x3 * x1 * d31 + y3 * x1 * x2 * d12;
        f.c0 = scaled_quot(n0, den, f.clip);
        f.c1 = scaled_quot(n1, den, f.clip);
        f.c2 = scaled_quot(n2, den, f.clip);
      end
      pending.push_back(f);
    endfunction

    function void check_fit(fit_t got);
      fit_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transaction c0=%0d", $time, got.c0);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.c0 !== e.c0) begin
        $display("%0t: c0 exp %0d got %0d", $time, e.c0, got.c0); errors++;
      end
      if (got.c1 !== e.c1) begin
        $display("%0t: c1 exp %0d got %0d", $time, e.c1, got.c1); errors++;
      end
      if (got.c2 !== e.c2) begin
        $display("%0t: c2 exp %0d got %0d", $time, e.c2, got.c2); errors++;
      end
      if (got.status !== e.status) begin
        $display("%0t: status exp %0b got %0b", $time, e.status, got.status); errors++;
      end
      if (got.clip !== e.clip) begin
        $display("%0t: clipped exp %0b got %0b", $time, e.clip, got.clip); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [XW-1:0] in_x_first = '0, in_x_second = '0, in_x_third = '0;
  logic signed [YW-1:0] in_y_first = '0, in_y_second = '0, in_y_third = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [OW-1:0] out_coef_const, out_coef_linear, out_coef_square;
  logic out_fit_status, out_clipped;

  fit_board board = new();
  bit feeding_done = 1'b0;
  bit burst_in, burst_out;
  int out_wait = 0;

  three_point_parabola_fit DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_points(logic signed [XW-1:0] xa, logic signed [YW-1:0] ya,
                             logic signed [XW-1:0] xb, logic signed [YW-1:0] yb,
                             logic signed [XW-1:0] xc, logic signed [YW-1:0] yc);
    int gap;
    gap = burst_in ? 0 : $urandom_range(10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_first <= xa; in_y_first <= ya;
    in_x_second <= xb; in_y_second <= yb;
    in_x_third <= xc; in_y_third <= yc;
    do @(posedge clk); while (in_stall);
    board.note_points(xa, ya, xb, yb, xc, yc);
  endtask

  function automatic logic signed [XW-1:0] rand_x();
    case ($urandom_range(3))
      0: return XW'($urandom_range(16) - 8);
      1: return $urandom_range(1) ? XW'(16'sh7fff - $urandom_range(3))
                                  : XW'(16'sh8000 + $urandom_range(3));
      default: return XW'($urandom);
    endcase
  endfunction

  function automatic logic signed [YW-1:0] rand_y();
    case ($urandom_range(3))
      0: return YW'($urandom_range(200) - 100);
      1: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      default: return YW'($urandom);
    endcase
  endfunction

  // output side: draw a wait for each transaction, check each transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_fit('{out_coef_const, out_coef_linear, out_coef_square,
                        out_fit_status, out_clipped});
    if (!rst_n) begin
      out_wait = 0;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_wait = burst_out ? 0 : $urandom_range(10);
      out_stall <= (out_wait != 0);
    end else begin
      if (out_wait > 0) out_wait--;
      out_stall <= (out_wait != 0);
    end
  end

  initial begin
    logic signed [XW-1:0] xa, xb, xc;
    logic signed [YW-1:0] ya;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // extremes, coinciding abscissas, unordered points, saturation
    send_points(-16'sd1, 24'sd1, 16'sd0, 24'sd0, 16'sd1, 24'sd1);
    send_points(16'sh8000, 24'sh7fffff, 16'sh7fff, 24'sh800000, 16'sd0, 24'sh7fffff);
    send_points(16'sh7fff, 24'sh800000, 16'sh8000, 24'sh7fffff, 16'sh7ffe, 24'sh800000);
    send_points(16'sd0, 24'sh7fffff, 16'sd1, 24'sh800000, 16'sd2, 24'sh7fffff);
    send_points(16'sd0, 24'sh800000, 16'sd1, 24'sh7fffff, 16'sd2, 24'sh800000);
    send_points(16'sd3, 24'sd5, 16'sd3, 24'sd7, 16'sd9, 24'sd1);
    send_points(16'sd3, 24'sd5, 16'sd4, 24'sd7, 16'sd3, 24'sd1);
    send_points(16'sd2, 24'sd5, 16'sd4, 24'sd7, 16'sd4, 24'sd1);
    send_points(16'sd5, 24'sd5, 16'sd5, 24'sd5, 16'sd5, 24'sd5);
    send_points(16'sh7fff, 24'sh7fffff, 16'sh7ffe, 24'sh800000, 16'sh7ffd, 24'sh7fffff);
    send_points(-16'sh7fff, 24'sh7fffff, 16'sh7fff, -24'sd1, 16'sh8000, 24'sh800000);
    send_points(16'sd10, 24'sd100, 16'sd5, 24'sd25, -16'sd3, 24'sd9);
    send_points(-16'sd1, -24'sd1, -16'sd2, -24'sd2, -16'sd3, -24'sd3);
    send_points(16'sh5555, 24'shaaaaaa, 16'shaaaa, 24'sh555555, 16'sh0f0f, 24'shf0f0f0);
    for (int i = 0; i < 900; i++) begin
      if (i % 100 == 0) burst_in = 1'($urandom_range(1));
      if (i % 150 == 0) burst_out = 1'($urandom_range(1));
      xa = rand_x(); xb = rand_x(); xc = rand_x(); ya = rand_y();
      if ($urandom_range(15) == 0) xb = xa;
      if ($urandom_range(15) == 0) xc = $urandom_range(1) ? xa : xb;
      send_points(xa, ya, xb, rand_y(), xc, rand_y());
    end
    in_valid <= 1'b0;
    burst_out = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (VL + 20) @(posedge clk);
    if (board.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
